// File: design/perceptron_online_trainer_unit_assert.svh
// assertion macros for the perceptron trainer
// expects aclk and aresetn in the scope of the module that includes it
`ifndef PERCEPTRON_ONLINE_TRAINER_UNIT_ASSERT_SVH
`define PERCEPTRON_ONLINE_TRAINER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define PTU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define PTU_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);
`else
`define PTU_ASSERT(lbl, prop, msg)
`define PTU_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// File: design/ptu_pkg.sv
// shared types and constants of the perceptron trainer
// no dependencies
package ptu_pkg;

    localparam int FEAT_W  = 16;
    localparam int WGT_W   = 32;
    localparam int ETA_W   = 16;
    localparam int THR_W   = 32;
    localparam int NEAR_W  = 16;
    localparam int OPA_W   = WGT_W + 1;
    localparam int OPB_W   = FEAT_W + 2;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int CFG_IDX_W = 8;

    typedef logic signed [FEAT_W-1:0] feat_t;
    typedef logic signed [WGT_W-1:0]  wgt_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

    localparam cfg_idx_t CFG_LEARNING_RATE     = 8'd0;
    localparam cfg_idx_t CFG_THRESHOLD_SQUARED = 8'd1;

    localparam logic [ETA_W-1:0] ETA_RESET = 16'd6554;
    localparam logic [THR_W-1:0] THR_RESET = 32'd4295;

    typedef logic [1:0] mac_sel_t;
    localparam mac_sel_t MAC_DOT  = 2'd0;
    localparam mac_sel_t MAC_STEP = 2'd1;
    localparam mac_sel_t MAC_SQR  = 2'd2;

    typedef struct packed {
        mac_sel_t sel;
        logic     acc_init;
        logic     acc_add;
    } mac_ctrl_t;

endpackage

// File: design/ptu_mac.sv
// shared multiply-accumulate unit: operand select, registered product, accumulator
// depends on ptu_pkg
module ptu_mac (
    input  logic                          aclk,
    input  ptu_pkg::mac_ctrl_t            ctrl,
    input  ptu_pkg::wgt_t                 weight,
    input  ptu_pkg::feat_t                feature,
    input  logic [ptu_pkg::ETA_W-1:0]     eta,
    input  logic [ptu_pkg::NEAR_W-1:0]    dist_mag,
    input  ptu_pkg::acc_t                 acc_init_val,
    output ptu_pkg::prod_t                prod,
    output ptu_pkg::acc_t                 acc
);
    import ptu_pkg::*;

    logic signed [OPA_W-1:0] op_a;
    logic signed [OPB_W-1:0] op_b;
    prod_t prod_reg;
    acc_t  acc_reg;

    always_comb begin
        case (ctrl.sel)
            MAC_DOT: begin
                op_a = OPA_W'(weight);
                op_b = OPB_W'(feature);
            end
            MAC_STEP: begin
                op_a = OPA_W'(feature);
                op_b = OPB_W'($signed({1'b0, eta}));
            end
            MAC_SQR: begin
                op_a = OPA_W'($signed({1'b0, dist_mag}));
                op_b = OPB_W'($signed({1'b0, dist_mag}));
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (ctrl.acc_init) begin
            acc_reg <= acc_init_val;
        end else if (ctrl.acc_add) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

// File: design/perceptron_online_trainer_unit.sv
// Online perceptron trainer. Samples enter on s_ (tdata: feature_0 .. feature_N-1,
// tuser: label); one result per sample leaves on m_ (tdata: weight_0 .. weight_N-1,
// bias; tuser: mistake, converged, ignored). Registers are written on the cfg_ channel.
// One shared multiplier under a sequencer does every product: N dot-product terms and
// N squared weight deltas, each followed by an accumulate, and N weight steps on a
// mistake, each written back to its weight, so the multiplier sets the rate.
// A sample runs through the dot product, the decision, the weight update on a mistake,
// the distance check and the result load; a sample ignored after convergence goes
// straight to the result load. One sample is in work at a time; the next request is
// taken in the cycle after the result is loaded.
// The result sits in an output register: a new sample may be accepted while it waits,
// and a finished result holds in the last step until m_tready frees the register.
// Synchronous active-low reset clears weights, previous weights, bias and the
// converged flag and restores the default learning rate and threshold.
// Configuration must be written only while no sample is in work; the block itself does not enforce this.
// depends on ptu_pkg, ptu_mac and perceptron_online_trainer_unit_assert.svh
`include "perceptron_online_trainer_unit_assert.svh"

module perceptron_online_trainer_unit #(
    parameter int NUM_FEATURES = 4
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // feature_0 .. feature_N-1
    input  logic [NUM_FEATURES*ptu_pkg::FEAT_W-1:0]      s_tdata,
    // label
    input  logic [0:0]                                   s_tuser,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // weight_0 .. weight_N-1, bias
    output logic [(NUM_FEATURES+1)*ptu_pkg::WGT_W-1:0]   m_tdata,
    // mistake, converged, ignored
    output logic [2:0]                                   m_tuser,
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  ptu_pkg::cfg_idx_t                            cfg_index,
    input  logic [ptu_pkg::THR_W-1:0]                    cfg_data
);
    import ptu_pkg::*;

    localparam int CNT_W = $clog2(NUM_FEATURES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_FEATURES);
    localparam int OUT_W = (NUM_FEATURES + 1) * WGT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DOT    = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_UPD    = 3'd3;
    localparam logic [2:0] S_DIST   = 3'd4;
    localparam logic [2:0] S_CHECK  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    wgt_t              wgt_reg [NUM_FEATURES];
    wgt_t              wgt_next [NUM_FEATURES];
    wgt_t              prev_reg [NUM_FEATURES];
    wgt_t              prev_next [NUM_FEATURES];
    feat_t             feat_reg [NUM_FEATURES];
    feat_t             feat_next [NUM_FEATURES];
    wgt_t              bias_reg, bias_next;
    logic              label_reg, label_next;
    logic              mistake_reg, mistake_next;
    logic              ignored_reg, ignored_next;
    logic              far_reg, far_next;
    logic              done_reg, done_next;
    logic [ETA_W-1:0]  eta_reg, eta_next;
    logic [THR_W-1:0]  thr_reg, thr_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [2:0]        m_tuser_reg, m_tuser_next;

    mac_ctrl_t         mac_ctrl;
    acc_t              acc_init_val;
    prod_t             prod;
    acc_t              acc;
    acc_t              bias_scaled;
    prod_t             step_rnd;
    prod_t             step;
    logic signed [WGT_W+1:0] wgt_sum;
    logic signed [WGT_W+1:0] bias_sum;
    wgt_t              wgt_new;
    logic signed [WGT_W:0]   dist_d;
    logic [WGT_W:0]    dist_abs;
    logic              far_now;
    logic              issue;
    logic              wback;
    logic              mistake_now;
    logic              conv_now;

    function automatic wgt_t sat_wgt(input logic signed [WGT_W+1:0] v);
        wgt_t r;
        if (v[WGT_W+1:WGT_W-1] == 3'b000 || v[WGT_W+1:WGT_W-1] == 3'b111) begin
            r = v[WGT_W-1:0];
        end else if (v[WGT_W+1]) begin
            r = {1'b1, {(WGT_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(WGT_W-1){1'b1}}};
        end
        return r;
    endfunction

    ptu_mac u_mac (
        .aclk         (aclk),
        .ctrl         (mac_ctrl),
        .weight       (wgt_reg[0]),
        .feature      (feat_reg[0]),
        .eta          (eta_reg),
        .dist_mag     (dist_abs[NEAR_W-1:0]),
        .acc_init_val (acc_init_val),
        .prod         (prod),
        .acc          (acc)
    );

    assign issue = (cnt_reg != CNT_LAST);
    assign wback = (cnt_reg != '0);

    assign bias_scaled  = acc_t'(bias_reg) <<< 8;
    assign acc_init_val = (state_reg == S_IDLE) ? bias_scaled : '0;

    // eta*x rounded to nearest, ties up, then Q8.24 to Q16.16
    assign step_rnd = prod + PROD_W'(128);
    assign step     = step_rnd >>> 8;
    assign wgt_sum  = label_reg ? ((WGT_W+2)'(wgt_reg[0]) + (WGT_W+2)'(step))
                                : ((WGT_W+2)'(wgt_reg[0]) - (WGT_W+2)'(step));
    assign wgt_new  = sat_wgt(wgt_sum);
    assign bias_sum = label_reg ? ((WGT_W+2)'(bias_reg) + (WGT_W+2)'({1'b0, eta_reg}))
                                : ((WGT_W+2)'(bias_reg) - (WGT_W+2)'({1'b0, eta_reg}));

    assign dist_d   = (WGT_W+1)'(wgt_reg[0]) - (WGT_W+1)'(prev_reg[0]);
    assign dist_abs = dist_d[WGT_W] ? (WGT_W+1)'(-dist_d) : (WGT_W+1)'(dist_d);
    assign far_now  = |dist_abs[WGT_W:NEAR_W];

    assign mistake_now = label_reg ? (acc[ACC_W-1] || acc == '0) : !acc[ACC_W-1];
    assign conv_now    = done_reg ||
                         (!ignored_reg && !far_reg && acc <= acc_t'({1'b0, thr_reg}));

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        wgt_next      = wgt_reg;
        prev_next     = prev_reg;
        feat_next     = feat_reg;
        bias_next     = bias_reg;
        label_next    = label_reg;
        mistake_next  = mistake_reg;
        ignored_next  = ignored_reg;
        far_next      = far_reg;
        done_next     = done_reg;
        eta_next      = eta_reg;
        thr_next      = thr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mac_ctrl      = '{sel: MAC_DOT, acc_init: 1'b0, acc_add: 1'b0};

        if (cfg_valid) begin
            case (cfg_index)
                CFG_LEARNING_RATE:     eta_next = cfg_data[ETA_W-1:0];
                CFG_THRESHOLD_SQUARED: thr_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    for (int i = 0; i < NUM_FEATURES; i++) begin
                        feat_next[i] = feat_t'(s_tdata[i*FEAT_W +: FEAT_W]);
                    end
                    label_next   = s_tuser[0];
                    cnt_next     = '0;
                    mistake_next = 1'b0;
                    far_next     = 1'b0;
                    if (done_reg) begin
                        ignored_next = 1'b1;
                        state_next   = S_CHECK;
                    end else begin
                        ignored_next      = 1'b0;
                        mac_ctrl.acc_init = 1'b1;
                        state_next        = S_DOT;
                    end
                end
            end
            S_DOT: begin
                mac_ctrl.sel     = MAC_DOT;
                mac_ctrl.acc_add = wback;
                if (issue) begin
                    for (int i = 0; i < NUM_FEATURES - 1; i++) begin
                        feat_next[i] = feat_reg[i+1];
                        wgt_next[i]  = wgt_reg[i+1];
                    end
                    feat_next[NUM_FEATURES-1] = feat_reg[0];
                    wgt_next[NUM_FEATURES-1]  = wgt_reg[0];
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                end else begin
                    cnt_next   = '0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                mac_ctrl.acc_init = 1'b1;
                mistake_next      = mistake_now;
                cnt_next          = '0;
                if (mistake_now) begin
                    bias_next  = sat_wgt(bias_sum);
                    state_next = S_UPD;
                end else begin
                    state_next = S_DIST;
                end
            end
            S_UPD: begin
                mac_ctrl.sel = MAC_STEP;
                if (issue) begin
                    for (int i = 0; i < NUM_FEATURES - 1; i++) begin
                        feat_next[i] = feat_reg[i+1];
                    end
                    feat_next[NUM_FEATURES-1] = feat_reg[0];
                end
                if (wback) begin
                    for (int i = 0; i < NUM_FEATURES - 1; i++) begin
                        wgt_next[i]  = wgt_reg[i+1];
                        prev_next[i] = prev_reg[i+1];
                    end
                    wgt_next[NUM_FEATURES-1]  = wgt_new;
                    prev_next[NUM_FEATURES-1] = wgt_reg[0];
                end
                if (issue) begin
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                end else begin
                    cnt_next   = '0;
                    state_next = S_DIST;
                end
            end
            S_DIST: begin
                mac_ctrl.sel     = MAC_SQR;
                mac_ctrl.acc_add = wback;
                if (issue) begin
                    for (int i = 0; i < NUM_FEATURES - 1; i++) begin
                        wgt_next[i]  = wgt_reg[i+1];
                        prev_next[i] = prev_reg[i+1];
                    end
                    wgt_next[NUM_FEATURES-1]  = wgt_reg[0];
                    prev_next[NUM_FEATURES-1] = prev_reg[0];
                    far_next = far_reg || far_now;
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                end else begin
                    cnt_next   = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!m_tvalid_reg || m_tready) begin
                    done_next     = conv_now;
                    m_tvalid_next = 1'b1;
                    for (int i = 0; i < NUM_FEATURES; i++) begin
                        m_tdata_next[i*WGT_W +: WGT_W] = wgt_reg[i];
                    end
                    m_tdata_next[NUM_FEATURES*WGT_W +: WGT_W] = bias_reg;
                    m_tuser_next = {ignored_reg, conv_now, mistake_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            bias_reg     <= '0;
            done_reg     <= 1'b0;
            eta_reg      <= ETA_RESET;
            thr_reg      <= THR_RESET;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_FEATURES; i++) begin
                wgt_reg[i]  <= '0;
                prev_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            bias_reg     <= bias_next;
            done_reg     <= done_next;
            eta_reg      <= eta_next;
            thr_reg      <= thr_next;
            m_tvalid_reg <= m_tvalid_next;
            wgt_reg      <= wgt_next;
            prev_reg     <= prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        feat_reg    <= feat_next;
        label_reg   <= label_next;
        mistake_reg <= mistake_next;
        ignored_reg <= ignored_next;
        far_reg     <= far_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    `PTU_ASSERT(a_ignored_converged, m_tvalid && m_tuser[2] |-> m_tuser[1], "ignored without converged")
    `PTU_ASSERT(a_mistake_not_ignored, m_tvalid |-> !(m_tuser[0] && m_tuser[2]), "mistake on ignored request")
    `PTU_ASSERT_NEXT(a_done_sticky, done_reg, done_reg, "converged flag dropped")
    `PTU_ASSERT(a_cnt_range, cnt_reg <= CNT_LAST, "step counter out of range")
    `PTU_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_reg != S_IDLE, "accept did not start work")

endmodule
